/* rtl/clipped_alpha_keyed_blitter_macros.svh */
// ----------------------------------------------------------------------------
// Clipped alpha keyed blitter assertion macros
// Shared concurrent assertion forms, clocked on clk of the including module.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_ALPHA_KEYED_BLITTER_MACROS_SVH
`define CLIPPED_ALPHA_KEYED_BLITTER_MACROS_SVH

// Check a property outside reset.
`define CAKB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property at every edge, reset included.
`define CAKB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/cakb_pkg.sv */
// ----------------------------------------------------------------------------
// Clipped alpha keyed blitter package
// Field widths, register indexes, stream layouts and pixel helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cakb_pkg;

  localparam int DIM_W      = 13;
  localparam int ADDR_W     = 24;
  localparam int COORD_W    = 16;
  localparam int PIX_W      = 32;
  localparam int COLOUR_W   = 24;
  localparam int CLIP_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 152;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_RED_BLUE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOUR   = 3'd6;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;
  localparam logic [PIX_W-1:0] KEEP_AG_MASK = 32'hFF00FF00;

  localparam logic [DIM_W-1:0] SOURCE_WIDTH_RST  = 13'd320;
  localparam logic [DIM_W-1:0] SOURCE_HEIGHT_RST = 13'd240;
  localparam logic [DIM_W-1:0] TARGET_WIDTH_RST  = 13'd320;
  localparam logic [DIM_W-1:0] TARGET_HEIGHT_RST = 13'd240;

  // Result layout bit positions, used by the port checker.
  localparam int OUT_JOB_VALID_BIT = 0;
  localparam int OUT_CLIP_LSB      = 1;
  localparam int OUT_SKIP_MSB      = 89;
  localparam int OUT_PIX_LSB       = 114;
  localparam int OUT_WE_BIT        = 146;

  // Input item, lowest field last.
  typedef struct packed {
    logic [PIX_W-1:0]          src_pixel;
    logic                      has_dst_rect;
    logic signed [COORD_W-1:0] dst_pos_y;
    logic signed [COORD_W-1:0] dst_pos_x;
    logic                      has_src_rect;
    logic [COORD_W-1:0]        src_rect_h;
    logic [COORD_W-1:0]        src_rect_w;
    logic signed [COORD_W-1:0] src_rect_y;
    logic signed [COORD_W-1:0] src_rect_x;
  } in_item_t;

  // Result item without the last flag, lowest field last.
  typedef struct packed {
    logic              write_enable;
    logic [PIX_W-1:0]  pixel_out;
    logic [ADDR_W-1:0] dst_addr;
    logic [DIM_W-1:0]  src_row_skip;
    logic [ADDR_W-1:0] src_start_addr;
    logic [DIM_W-1:0]  clipped_h;
    logic [DIM_W-1:0]  clipped_w;
    logic [DIM_W-1:0]  clipped_y;
    logic [DIM_W-1:0]  clipped_x;
    logic              job_valid;
  } out_item_t;

  localparam int IN_ITEM_W  = $bits(in_item_t);
  localparam int OUT_ITEM_W = $bits(out_item_t);

  function automatic logic [PIX_W-1:0] swap_rb(input logic [PIX_W-1:0] p);
    return (p & KEEP_AG_MASK) | {8'h00, p[7:0], 8'h00, p[23:16]};
  endfunction

endpackage

/* rtl/clipped_alpha_keyed_blitter.sv */
// ----------------------------------------------------------------------------
// Clipped alpha keyed blitter
// Clips blit jobs against both surfaces and maps streamed source pixels to
// destination addresses with an alpha key, copy or fill, and red/blue swap.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_*     slave      tuser: command; tdata: start fields and source pixel
//  out_*    master     tdata: start reply and pixel reply fields; tlast: last
//  cfg_*    write      index 0..6, register data in the low bits
//
//  One item per cycle sustained while results are taken; from transfer to result
//  an item passes an input register, then clipping or pixel logic into the
//  result register. The start path is set by the clip compares and two 13x13 multiplies.
//  Synchronous reset loads the register defaults and clears the job.
//  A stalled result holds; the input register keeps taking items while the
//  result register drains in the same cycle.
`timescale 1ns / 1ps

module clipped_alpha_keyed_blitter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // tdata: src_rect_x, src_rect_y, src_rect_w, src_rect_h, has_src_rect,
  //        dst_pos_x, dst_pos_y, has_dst_rect, src_pixel, zero pad
  input  logic [cakb_pkg::IN_DATA_W-1:0]         in_tdata,
  // tuser: command
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // tdata: job_valid, clipped_x, clipped_y, clipped_w, clipped_h,
  //        src_start_addr, src_row_skip, dst_addr, pixel_out, write_enable,
  //        zero pad
  output logic [cakb_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tlast,
  input  logic                                   cfg_wen,
  input  logic [cakb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cakb_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int DW = cakb_pkg::DIM_W;
  localparam int AW = cakb_pkg::ADDR_W;
  localparam int CW = cakb_pkg::CLIP_W;

  // Configuration registers
  logic [DW-1:0]                  src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic                           fill_mode_r, swap_rb_r;
  logic [cakb_pkg::COLOUR_W-1:0]  fill_colour_r;
  logic [DW-1:0]                  cfg_dim;

  assign cfg_dim = (cfg_wdata[DW-1:0] > cakb_pkg::MAX_DIM) ? cakb_pkg::MAX_DIM
                                                          : cfg_wdata[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r       <= cakb_pkg::SOURCE_WIDTH_RST;
      src_h_r       <= cakb_pkg::SOURCE_HEIGHT_RST;
      tgt_w_r       <= cakb_pkg::TARGET_WIDTH_RST;
      tgt_h_r       <= cakb_pkg::TARGET_HEIGHT_RST;
      fill_mode_r   <= 1'b0;
      swap_rb_r     <= 1'b0;
      fill_colour_r <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        cakb_pkg::REG_SOURCE_WIDTH:  src_w_r       <= cfg_dim;
        cakb_pkg::REG_SOURCE_HEIGHT: src_h_r       <= cfg_dim;
        cakb_pkg::REG_TARGET_WIDTH:  tgt_w_r       <= cfg_dim;
        cakb_pkg::REG_TARGET_HEIGHT: tgt_h_r       <= cfg_dim;
        cakb_pkg::REG_FILL_MODE:     fill_mode_r   <= cfg_wdata[0];
        cakb_pkg::REG_SWAP_RED_BLUE: swap_rb_r     <= cfg_wdata[0];
        cakb_pkg::REG_FILL_COLOUR:   fill_colour_r <= cfg_wdata[cakb_pkg::COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_cmd_r;
  cakb_pkg::in_item_t   s1_item_r;
  logic                 in_xfer, s1_go;
  logic                 out_valid_r, out_valid_nxt;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    priority if (in_xfer) s1_valid_nxt = 1'b1;
    else if (s1_go)       s1_valid_nxt = 1'b0;
    else                  s1_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r  <= in_tuser;
      s1_item_r <= cakb_pkg::in_item_t'(in_tdata[cakb_pkg::IN_ITEM_W-1:0]);
    end
  end

  // Clipping
  logic signed [CW-1:0] sx, sy, w, h, dx, dy;
  logic signed [CW-1:0] swc, shc, twc, thc;
  logic                 region_ok;

  always_comb begin
    swc = signed'({{(CW-DW){1'b0}}, src_w_r});
    shc = signed'({{(CW-DW){1'b0}}, src_h_r});
    twc = signed'({{(CW-DW){1'b0}}, tgt_w_r});
    thc = signed'({{(CW-DW){1'b0}}, tgt_h_r});
    if (s1_item_r.has_src_rect) begin
      sx = CW'(s1_item_r.src_rect_x);
      sy = CW'(s1_item_r.src_rect_y);
      w  = signed'({{(CW-cakb_pkg::COORD_W){1'b0}}, s1_item_r.src_rect_w});
      h  = signed'({{(CW-cakb_pkg::COORD_W){1'b0}}, s1_item_r.src_rect_h});
      if (sx < 0) begin
        w  = w + sx;
        sx = '0;
      end
      if (sy < 0) begin
        h  = h + sy;
        sy = '0;
      end
    end else begin
      sx = '0;
      sy = '0;
      w  = swc;
      h  = shc;
    end
    if (s1_item_r.has_dst_rect) begin
      dx = CW'(s1_item_r.dst_pos_x);
      dy = CW'(s1_item_r.dst_pos_y);
      if (dx < 0) begin
        sx = sx - dx;
        w  = w + dx;
        dx = '0;
      end
      if (dy < 0) begin
        sy = sy - dy;
        h  = h + dy;
        dy = '0;
      end
    end else begin
      dx = '0;
      dy = '0;
    end
    region_ok = !(sx > swc || sy > shc || dx > twc || dy > thc);
    if (dx + w > twc) w = twc - dx;
    if (dy + h > thc) h = thc - dy;
    if (sx + w > swc) w = swc - sx;
    if (sy + h > shc) h = shc - sy;
    region_ok = region_ok && (w > 0) && (h > 0);
  end

  // First source and destination addresses
  logic [2*DW-1:0] src_prod, dst_prod;
  logic [AW-1:0]   src_start, dst_first;

  always_comb begin
    src_prod  = sy[DW-1:0] * src_w_r;
    dst_prod  = dy[DW-1:0] * tgt_w_r;
    src_start = AW'(src_prod + {{DW{1'b0}}, sx[DW-1:0]});
    dst_first = AW'(dst_prod + {{DW{1'b0}}, dx[DW-1:0]});
  end

  // Job state
  logic          job_active_r, job_active_nxt;
  logic [DW-1:0] col_r, col_nxt, rows_r, rows_nxt, rw_r, rw_nxt, dskip_r, dskip_nxt;
  logic [AW-1:0] daddr_r, daddr_nxt;
  logic [DW-1:0] col_inc;
  logic          final_px;
  logic [cakb_pkg::PIX_W-1:0] px;

  assign col_inc  = col_r + 1'b1;
  assign final_px = (col_inc == rw_r) && (rows_r == {{(DW-1){1'b0}}, 1'b1});

  always_comb begin
    px = fill_mode_r ? {cakb_pkg::ALPHA_OPAQUE, fill_colour_r} : s1_item_r.src_pixel;
    if (swap_rb_r) px = cakb_pkg::swap_rb(px);
  end

  always_comb begin
    job_active_nxt = job_active_r;
    col_nxt        = col_r;
    rows_nxt       = rows_r;
    rw_nxt         = rw_r;
    dskip_nxt      = dskip_r;
    daddr_nxt      = daddr_r;
    if (s1_go) begin
      if (s1_cmd_r == cakb_pkg::CMD_START) begin
        // A new start drops any running job.
        job_active_nxt = region_ok;
        if (region_ok) begin
          col_nxt   = '0;
          rows_nxt  = h[DW-1:0];
          rw_nxt    = w[DW-1:0];
          daddr_nxt = dst_first;
          dskip_nxt = tgt_w_r - w[DW-1:0];
        end
      end else if (job_active_r) begin
        if (col_inc >= rw_r) begin
          col_nxt   = '0;
          rows_nxt  = rows_r - 1'b1;
          daddr_nxt = daddr_r + {{(AW-DW){1'b0}}, dskip_r} + 1'b1;
          if (rows_r == {{(DW-1){1'b0}}, 1'b1}) job_active_nxt = 1'b0;
        end else begin
          col_nxt   = col_inc;
          daddr_nxt = daddr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_active_r <= 1'b0;
      col_r        <= '0;
      rows_r       <= '0;
      rw_r         <= '0;
      dskip_r      <= '0;
      daddr_r      <= '0;
    end else begin
      job_active_r <= job_active_nxt;
      col_r        <= col_nxt;
      rows_r       <= rows_nxt;
      rw_r         <= rw_nxt;
      dskip_r      <= dskip_nxt;
      daddr_r      <= daddr_nxt;
    end
  end

  // Result register
  cakb_pkg::out_item_t res_nxt, res_r;
  logic                last_nxt, last_r;

  always_comb begin
    res_nxt  = '0;
    last_nxt = 1'b0;
    if (s1_cmd_r == cakb_pkg::CMD_START) begin
      if (region_ok) begin
        res_nxt.job_valid      = 1'b1;
        res_nxt.clipped_x      = sx[DW-1:0];
        res_nxt.clipped_y      = sy[DW-1:0];
        res_nxt.clipped_w      = w[DW-1:0];
        res_nxt.clipped_h      = h[DW-1:0];
        res_nxt.src_start_addr = src_start;
        res_nxt.src_row_skip   = src_w_r - w[DW-1:0];
        res_nxt.dst_addr       = dst_first;
      end
    end else if (job_active_r) begin
      res_nxt.dst_addr     = daddr_r;
      res_nxt.pixel_out    = px;
      res_nxt.write_enable = (s1_item_r.src_pixel[31:24] != 8'h00);
      last_nxt             = final_px;
    end
  end

  always_comb begin
    priority if (s1_go)   out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res_r  <= res_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cakb_pkg::OUT_DATA_W-cakb_pkg::OUT_ITEM_W){1'b0}}, res_r};
  assign out_tlast  = last_r;

endmodule

/* rtl/cakb_checker.sv */
// ----------------------------------------------------------------------------
// Clipped alpha keyed blitter port checker
// Watches the result channel of the blitter and flags illegal sequences.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "clipped_alpha_keyed_blitter_macros.svh"

module cakb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cakb_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tlast
);

  // Hold a stalled result.
  `CAKB_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // Drop any pending result on reset.
  `CAKB_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid, "result valid after reset")

  // A start reply with a job carries no pixel write and no last flag.
  `CAKB_ASSERT(a_start_no_pixel, out_tvalid && out_tdata[cakb_pkg::OUT_JOB_VALID_BIT] |-> out_tdata[cakb_pkg::OUT_WE_BIT:cakb_pkg::OUT_PIX_LSB] == '0 && !out_tlast, "start reply with pixel fields")

  // Pixel replies and empty starts leave the clip fields clear.
  `CAKB_ASSERT(a_clip_clear, out_tvalid && !out_tdata[cakb_pkg::OUT_JOB_VALID_BIT] |-> out_tdata[cakb_pkg::OUT_SKIP_MSB:cakb_pkg::OUT_CLIP_LSB] == '0, "clip fields set without a job")

endmodule

bind clipped_alpha_keyed_blitter cakb_checker u_cakb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* tb/clipped_alpha_keyed_blitter_tb.sv */
// ----------------------------------------------------------------------------
// Clipped alpha keyed blitter testbench
// Drives blit jobs and pixel streams under random back-pressure, predicts
// every reply from a model of the clip and pixel path, and compares each
// result transfer field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clipped_alpha_keyed_blitter_tb;
  import cakb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SEG_ITEMS   = 155;
  localparam int MAX_STREAM  = 150;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    out_item_t f;
    logic      last;
  } reply_t;

  class blit_scoreboard;
    logic [DIM_W-1:0]    src_w, src_h, dst_w, dst_h;
    logic                fill, swap;
    logic [COLOUR_W-1:0] colour;
    bit                  active;
    logic [DIM_W-1:0]    col, rows_left, region_w, dest_skip;
    logic [ADDR_W-1:0]   dest_addr;
    reply_t              pending_replies[$];
    int                  mismatches;

    function new();
      src_w = SOURCE_WIDTH_RST;
      src_h = SOURCE_HEIGHT_RST;
      dst_w = TARGET_WIDTH_RST;
      dst_h = TARGET_HEIGHT_RST;
      fill = 1'b0;
      swap = 1'b0;
      colour = '0;
      active = 1'b0;
      col = '0;
      rows_left = '0;
      region_w = '0;
      dest_skip = '0;
      dest_addr = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      logic [DIM_W-1:0] dim;
      dim = data[DIM_W-1:0];
      if (dim > MAX_DIM) dim = MAX_DIM;
      case (idx)
        REG_SOURCE_WIDTH:  src_w = dim;
        REG_SOURCE_HEIGHT: src_h = dim;
        REG_TARGET_WIDTH:  dst_w = dim;
        REG_TARGET_HEIGHT: dst_h = dim;
        REG_FILL_MODE:     fill = data[0];
        REG_SWAP_RED_BLUE: swap = data[0];
        REG_FILL_COLOUR:   colour = data;
        default: ;
      endcase
    endfunction

    // Clip a start request against both surfaces; 0 when the region is empty.
    function bit clip_job(in_item_t it, output reply_t r);
      longint sw, sh, tw, th, sx, sy, w, h, dx, dy, a;
      r = '0;
      sw = src_w;
      sh = src_h;
      tw = dst_w;
      th = dst_h;
      if (it.has_src_rect) begin
        sx = $signed(it.src_rect_x);
        sy = $signed(it.src_rect_y);
        w = it.src_rect_w;
        h = it.src_rect_h;
        if (sx < 0) begin
          w += sx;
          sx = 0;
        end
        if (sy < 0) begin
          h += sy;
          sy = 0;
        end
      end else begin
        sx = 0;
        sy = 0;
        w = sw;
        h = sh;
      end
      if (it.has_dst_rect) begin
        dx = $signed(it.dst_pos_x);
        dy = $signed(it.dst_pos_y);
        // a negative destination edge shifts the source window instead
        if (dx < 0) begin
          sx -= dx;
          w += dx;
          dx = 0;
        end
        if (dy < 0) begin
          sy -= dy;
          h += dy;
          dy = 0;
        end
      end else begin
        dx = 0;
        dy = 0;
      end
      if (sx > sw || sy > sh || dx > tw || dy > th) return 1'b0;
      if (dx + w > tw) w = tw - dx;
      if (dy + h > th) h = th - dy;
      if (sx + w > sw) w = sw - sx;
      if (sy + h > sh) h = sh - sy;
      if (w <= 0 || h <= 0) return 1'b0;
      r.f.job_valid = 1'b1;
      r.f.clipped_x = sx[DIM_W-1:0];
      r.f.clipped_y = sy[DIM_W-1:0];
      r.f.clipped_w = w[DIM_W-1:0];
      r.f.clipped_h = h[DIM_W-1:0];
      a = sy * sw + sx;
      r.f.src_start_addr = a[ADDR_W-1:0];
      a = sw - w;
      r.f.src_row_skip = a[DIM_W-1:0];
      a = dy * tw + dx;
      r.f.dst_addr = a[ADDR_W-1:0];
      return 1'b1;
    endfunction

    function void accept_item(logic cmd, in_item_t it);
      reply_t           r;
      logic [PIX_W-1:0] px;
      r = '0;
      if (cmd == CMD_START) begin
        active = clip_job(it, r);
        if (active) begin
          col = '0;
          rows_left = r.f.clipped_h;
          region_w = r.f.clipped_w;
          dest_addr = r.f.dst_addr;
          dest_skip = dst_w - r.f.clipped_w;
        end
      end else if (active) begin
        px = fill ? {ALPHA_OPAQUE, colour} : it.src_pixel;
        if (swap) px = {px[31:24], px[7:0], px[15:8], px[23:16]};
        r.f.dst_addr = dest_addr;
        r.f.pixel_out = px;
        r.f.write_enable = (it.src_pixel[31:24] != 8'h00);
        r.last = (col + 13'd1 == region_w) && (rows_left == 13'd1);
        col = col + 13'd1;
        if (col >= region_w) begin
          col = '0;
          rows_left = rows_left - 13'd1;
          dest_addr = dest_addr + 24'd1 + ADDR_W'(dest_skip);
          if (rows_left == '0) active = 1'b0;
        end else begin
          dest_addr = dest_addr + 24'd1;
        end
      end
      pending_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_reply(out_item_t got, logic got_last);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transfer with nothing expected: %h", got);
        return;
      end
      want = pending_replies.pop_front();
      compare_field("job_valid", PIX_W'(want.f.job_valid), PIX_W'(got.job_valid));
      compare_field("clipped_x", PIX_W'(want.f.clipped_x), PIX_W'(got.clipped_x));
      compare_field("clipped_y", PIX_W'(want.f.clipped_y), PIX_W'(got.clipped_y));
      compare_field("clipped_w", PIX_W'(want.f.clipped_w), PIX_W'(got.clipped_w));
      compare_field("clipped_h", PIX_W'(want.f.clipped_h), PIX_W'(got.clipped_h));
      compare_field("src_start_addr", PIX_W'(want.f.src_start_addr),
                    PIX_W'(got.src_start_addr));
      compare_field("src_row_skip", PIX_W'(want.f.src_row_skip), PIX_W'(got.src_row_skip));
      compare_field("dst_addr", PIX_W'(want.f.dst_addr), PIX_W'(got.dst_addr));
      compare_field("pixel_out", want.f.pixel_out, got.pixel_out);
      compare_field("write_enable", PIX_W'(want.f.write_enable), PIX_W'(got.write_enable));
      compare_field("last", PIX_W'(want.last), PIX_W'(got_last));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  blit_scoreboard sb;
  int             src_idle = 0;
  int             dst_idle = 0;
  int             items_sent = 0;
  int             stall_cycles = 0;

  clipped_alpha_keyed_blitter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= dst_idle);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.accept_item(in_tuser, in_item_t'(in_tdata[IN_ITEM_W-1:0]));
    if (rst_n && out_tvalid && out_tready)
      sb.check_reply(out_item_t'(out_tdata[OUT_ITEM_W-1:0]), out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("clipped_alpha_keyed_blitter test failed");
        $finish;
      end
    end
  end

  function automatic in_item_t random_item();
    logic [159:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return raw[IN_ITEM_W-1:0];
  endfunction

  function automatic in_item_t pixel_item();
    in_item_t it;
    it = random_item();
    if ($urandom_range(3) == 0) it.src_pixel[31:24] = 8'h00;
    else if ($urandom_range(7) == 0) it.src_pixel[31:24] = ALPHA_OPAQUE;
    return it;
  endfunction

  function automatic in_item_t start_item(int sx, int sy, int w, int h, bit hs,
                                          int dx, int dy, bit hd);
    in_item_t it;
    it = random_item();
    it.src_rect_x = 16'(sx);
    it.src_rect_y = 16'(sy);
    it.src_rect_w = 16'(w);
    it.src_rect_h = 16'(h);
    it.has_src_rect = hs;
    it.dst_pos_x = 16'(dx);
    it.dst_pos_y = 16'(dy);
    it.has_dst_rect = hd;
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int                    roll;
    logic [CFG_DATA_W-1:0] v;
    roll = $urandom_range(99);
    v = CFG_DATA_W'($urandom());
    if (roll < 3) v[DIM_W-1:0] = '0;
    else if (roll < 11) v[DIM_W-1:0] = 13'd1;
    else if (roll < 18) v[DIM_W-1:0] = MAX_DIM;
    else if (roll < 25) v[DIM_W-1:0] = 13'($urandom_range(8191, 4097));
    else if (roll < 45) v[DIM_W-1:0] = 13'($urandom_range(4096, 1));
    else v[DIM_W-1:0] = 13'($urandom_range(40, 1));
    return v;
  endfunction

  task automatic send_item(input logic cmd, input in_item_t it);
    if ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W-IN_ITEM_W){1'b0}}, it};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the input until every predicted reply has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_surfaces(input int g);
    logic [CFG_DATA_W-1:0] v[7];
    if (g == 0) begin
      // oversized sizes saturate to the largest surface
      v = '{24'hFFFFFF, 24'h001FFF, 24'hA01FFF, 24'h001FFF, 24'hFFFFFF, 24'hFFFFFF,
            24'hFFFFFF};
    end else if (g == 1) begin
      v = '{24'd1, 24'd1, 24'd1, 24'd1, 24'hFFFFFE, 24'd0, 24'd0};
    end else begin
      v = '{pick_size(), pick_size(), pick_size(), pick_size(), CFG_DATA_W'($urandom()),
            CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom())};
    end
    write_reg(REG_SOURCE_WIDTH, v[0]);
    write_reg(REG_SOURCE_HEIGHT, v[1]);
    write_reg(REG_TARGET_WIDTH, v[2]);
    write_reg(REG_TARGET_HEIGHT, v[3]);
    write_reg(REG_FILL_MODE, v[4]);
    write_reg(REG_SWAP_RED_BLUE, v[5]);
    write_reg(REG_FILL_COLOUR, v[6]);
    if (g == 2) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // One start near the live surfaces, then its pixel stream; sometimes cut short
  // or overrun so that abandoned jobs and pixels after the end get exercised.
  task automatic run_job();
    in_item_t it;
    reply_t   r;
    int       n;
    int       roll;
    it = random_item();
    it.has_src_rect = ($urandom_range(9) != 0);
    it.src_rect_x = 16'($urandom_range(sb.src_w + 4) - 4);
    it.src_rect_y = 16'($urandom_range(sb.src_h + 4) - 4);
    it.src_rect_w = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(10));
    it.src_rect_h = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(6));
    it.has_dst_rect = ($urandom_range(4) != 0);
    it.dst_pos_x = 16'($urandom_range(sb.dst_w + 4) - 4);
    it.dst_pos_y = 16'($urandom_range(sb.dst_h + 4) - 4);
    if (sb.clip_job(it, r)) n = int'(r.f.clipped_w) * int'(r.f.clipped_h);
    else n = 0;
    roll = $urandom_range(99);
    if (n > MAX_STREAM) n = $urandom_range(20, 1);
    else if (roll < 8 && n > 0) n = $urandom_range(n - 1);
    else if (roll < 14) n += $urandom_range(3, 1);
    send_item(CMD_START, it);
    repeat (n) send_item(CMD_PIXEL, pixel_item());
    items_sent += n + 1;
  endtask

  initial begin
    int phase;
    int seg;
    int seg_base;
    int roll;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle = 22;
    dst_idle = 56;
    // pixel with no job running
    send_item(CMD_PIXEL, pixel_item());
    // whole surfaces, then a few alpha cases before the job is abandoned
    send_item(CMD_START, start_item(0, 0, 0, 0, 1'b0, 0, 0, 1'b0));
    send_item(CMD_PIXEL, start_item(0, 0, 0, 0, 1'b0, 0, 0, 1'b0));
    send_item(CMD_PIXEL, start_item(-1, -1, 65535, 65535, 1'b1, -1, -1, 1'b1));
    send_item(CMD_PIXEL, start_item(-32768, 0, 0, 0, 1'b1, 0, 0, 1'b0));
    // out of bounds and empty regions
    send_item(CMD_START, start_item(-32768, 32767, 65535, 65535, 1'b1, 0, 0, 1'b0));
    send_item(CMD_START, start_item(32767, -32768, 65535, 65535, 1'b1, 32767, -32768, 1'b1));
    send_item(CMD_START, start_item(0, 0, 8, 8, 1'b1, -32768, 0, 1'b1));
    send_item(CMD_START, start_item(4, 4, 0, 5, 1'b1, 0, 0, 1'b0));
    // bottom-right corner clips to 2x2, then one pixel past the end
    send_item(CMD_START, start_item(318, 238, 4, 4, 1'b1, 318, 238, 1'b1));
    repeat (5) send_item(CMD_PIXEL, pixel_item());
    // negative destination edge, with the pixel mode changed mid-job
    send_item(CMD_START, start_item(5, 5, 4, 3, 1'b1, -2, -1, 1'b1));
    send_item(CMD_PIXEL, pixel_item());
    send_item(CMD_PIXEL, pixel_item());
    drain();
    write_reg(REG_FILL_MODE, 24'd1);
    write_reg(REG_SWAP_RED_BLUE, 24'd1);
    write_reg(REG_FILL_COLOUR, 24'h123456);
    cfg_wen <= 1'b0;
    @(posedge clk);
    send_item(CMD_PIXEL, start_item(0, 0, 0, 0, 1'b0, 0, 0, 1'b0));
    send_item(CMD_PIXEL, pixel_item());

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle = 22;
          dst_idle = 56;
        end
        1: begin
          src_idle = 56;
          dst_idle = 22;
        end
        default: begin
          src_idle = 0;
          dst_idle = 0;
        end
      endcase
      for (seg = 0; seg < 3; seg++) begin
        drain();
        program_surfaces(phase * 3 + seg);
        seg_base = items_sent;
        while (items_sent - seg_base < SEG_ITEMS) begin
          roll = $urandom_range(99);
          if (roll < 2) begin
            drain();
          end else if (roll < 12) begin
            send_item(CMD_START, random_item());
            items_sent++;
          end else if (roll < 18) begin
            repeat ($urandom_range(3, 1)) begin
              send_item(CMD_PIXEL, pixel_item());
              items_sent++;
            end
          end else begin
            run_job();
          end
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending_replies.size() != 0)
      $display("%0d expected results never arrived", sb.pending_replies.size());
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("clipped_alpha_keyed_blitter test passed");
    end else begin
      $display("clipped_alpha_keyed_blitter test failed");
    end
    $finish;
  end

endmodule
